### src/assert_macros.svh
// assertion helper macros for the anti-replay window rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define ARW_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define ARW_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/arw_pkg.sv
// shared types and constants for the anti-replay window
// no dependencies
`default_nettype none

package arw_pkg;

    localparam int COUNTER_W            = 64;
    localparam int WORD_W               = 64;
    localparam int BIT_W                = 6;
    localparam int STATUS_W             = 3;
    localparam int DEFAULT_WINDOW_WORDS = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW_HIGH  = 3'd0,
        ST_IN_WINDOW = 3'd1,
        ST_ZERO      = 3'd2,
        ST_TOO_OLD   = 3'd3,
        ST_REPLAY    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_CLASS,
        S_WSHIFT,
        S_BSHIFT,
        S_PROBE,
        S_DECIDE,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR_MARK,
        CELL_WORD_SHIFT,
        CELL_BIT_SHIFT_MARK,
        CELL_PROBE,
        CELL_SET
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [BIT_W-1:0]  bit_pos;
    } cell_cmd_t;

endpackage

`default_nettype wire

### src/arw_in_if.sv
// input channel: one packet counter per transaction
// depends on arw_pkg
`default_nettype none

interface arw_in_if;
    logic                          valid;
    logic                          ready;
    logic [arw_pkg::COUNTER_W-1:0] counter;

    modport source (output valid, output counter, input ready);
    modport sink   (input valid, input counter, output ready);
endinterface

`default_nettype wire

### src/arw_out_if.sv
// result channel: accept flag and reason code per transaction
// depends on arw_pkg
`default_nettype none

interface arw_out_if;
    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic [arw_pkg::STATUS_W-1:0] status;

    modport source (output valid, output accepted, output status, input ready);
    modport sink   (input valid, input accepted, input status, output ready);
endinterface

`default_nettype wire

### src/arw_cell.sv
// one 64-bit word of the seen bitmap, linked to its lower neighbor
// depends on arw_pkg
`default_nettype none

module arw_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire arw_pkg::cell_cmd_t         cmd,
    input  wire logic [IDX_W-1:0]           word_sel,
    input  wire logic [arw_pkg::WORD_W-1:0] prev_word,
    output logic      [arw_pkg::WORD_W-1:0] word,
    output logic                            hit
);

    localparam logic [arw_pkg::WORD_W-1:0] MARK_BIT =
        (INDEX == 0) ? arw_pkg::WORD_W'(1) : '0;

    logic [arw_pkg::WORD_W-1:0] word_reg, word_next;
    logic                       hit_reg, hit_next;
    logic                       sel;
    logic [arw_pkg::WORD_W-1:0] shifted;
    logic [arw_pkg::WORD_W-1:0] carry;
    logic [arw_pkg::BIT_W:0]    carry_amt;

    assign sel       = (word_sel == IDX_W'(INDEX));
    assign carry_amt = (arw_pkg::BIT_W+1)'(arw_pkg::WORD_W) - {1'b0, cmd.bit_pos};
    assign shifted   = word_reg << cmd.bit_pos;
    assign carry     = (cmd.bit_pos != '0) ? (prev_word >> carry_amt) : '0;

    always_comb
    begin
        word_next = word_reg;
        hit_next  = hit_reg;
        unique case (cmd.op)
            arw_pkg::CELL_HOLD:           word_next = word_reg;
            arw_pkg::CELL_CLEAR_MARK:     word_next = MARK_BIT;
            arw_pkg::CELL_WORD_SHIFT:     word_next = prev_word;
            arw_pkg::CELL_BIT_SHIFT_MARK: word_next = shifted | carry | MARK_BIT;
            arw_pkg::CELL_PROBE:          hit_next  = sel & word_reg[cmd.bit_pos];
            arw_pkg::CELL_SET:
            begin
                if (sel)
                begin
                    word_next = word_reg | (arw_pkg::WORD_W'(1) << cmd.bit_pos);
                end
            end
            default:                      word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            word_reg <= word_next;
            hit_reg  <= hit_next;
        end
    end

    assign word = word_reg;
    assign hit  = hit_reg;

endmodule

`default_nettype wire

### src/anti_replay_window.sv
// anti-replay sliding window: top level with sequencer and chain of bitmap cells
// depends on arw_pkg, arw_in_if, arw_out_if, arw_cell, assert_macros.svh
// sequence: zero, too old and large-jump counters go from class straight to done,
//   in-window checks probe and decide, a new highest in the window shifts any words, then bits
// throughput: one transaction at a time, a new counter is taken only back in idle, once the
//   result register is free, paced by the word-by-word walk of the bitmap along the cell chain
// reset: asynchronous active low, clears highest counter, bitmap and handshake state
`default_nettype none
`include "assert_macros.svh"

module anti_replay_window #(
    parameter int WINDOW_WORDS = arw_pkg::DEFAULT_WINDOW_WORDS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    arw_in_if.sink    pkt_in,
    arw_out_if.source res_out
);

    localparam int IDX_W = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1;
    localparam int WIDTH = WINDOW_WORDS * arw_pkg::WORD_W;

    // sequencer state
    arw_pkg::state_t state_reg, state_next;

    // per-transaction working registers
    logic [arw_pkg::COUNTER_W-1:0] cnt_reg;
    logic [arw_pkg::COUNTER_W-1:0] highest_reg;
    logic [arw_pkg::COUNTER_W-1:0] diff_reg;
    logic                          zero_reg;
    logic                          new_reg;
    logic [IDX_W-1:0]              wcnt_reg;
    logic                          res_acc_reg;
    arw_pkg::status_t              res_status_reg;

    // result output register
    logic                          out_valid_reg;
    logic                          out_acc_reg;
    arw_pkg::status_t              out_status_reg;

    // control decode
    arw_pkg::cell_cmd_t            cmd;
    logic                          too_far;
    logic [IDX_W-1:0]              word_sel;
    logic                          hit_any;
    logic                          out_free;

    // cell chain wiring
    logic [arw_pkg::WORD_W-1:0]    words [WINDOW_WORDS];
    logic [WINDOW_WORDS-1:0]       hits;

    // distance above or below the highest counter is in diff_reg from the class state on
    assign too_far  = (diff_reg >= arw_pkg::COUNTER_W'(WIDTH));
    assign word_sel = diff_reg[arw_pkg::BIT_W +: IDX_W];
    assign hit_any  = |hits;
    assign out_free = !out_valid_reg || res_out.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            arw_pkg::S_IDLE:
            begin
                if (pkt_in.valid)
                begin
                    state_next = arw_pkg::S_DIFF;
                end
            end
            arw_pkg::S_DIFF:   state_next = arw_pkg::S_CLASS;
            arw_pkg::S_CLASS:
            begin
                if (zero_reg || too_far)
                begin
                    state_next = arw_pkg::S_DONE;
                end
                else if (new_reg)
                begin
                    state_next = (word_sel != '0) ? arw_pkg::S_WSHIFT : arw_pkg::S_BSHIFT;
                end
                else
                begin
                    state_next = arw_pkg::S_PROBE;
                end
            end
            arw_pkg::S_WSHIFT:
            begin
                if (wcnt_reg == IDX_W'(1))
                begin
                    state_next = arw_pkg::S_BSHIFT;
                end
            end
            arw_pkg::S_BSHIFT: state_next = arw_pkg::S_DONE;
            arw_pkg::S_PROBE:  state_next = arw_pkg::S_DECIDE;
            arw_pkg::S_DECIDE: state_next = arw_pkg::S_DONE;
            arw_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = arw_pkg::S_IDLE;
                end
            end
            default:           state_next = arw_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer: cell commands and input handshake
    always_comb
    begin
        cmd.op      = arw_pkg::CELL_HOLD;
        cmd.bit_pos = diff_reg[arw_pkg::BIT_W-1:0];
        unique case (state_reg)
            arw_pkg::S_CLASS:
            begin
                // jump of a whole window or more: wipe and mark newest
                if (!zero_reg && new_reg && too_far)
                begin
                    cmd.op = arw_pkg::CELL_CLEAR_MARK;
                end
            end
            arw_pkg::S_WSHIFT: cmd.op = arw_pkg::CELL_WORD_SHIFT;
            arw_pkg::S_BSHIFT: cmd.op = arw_pkg::CELL_BIT_SHIFT_MARK;
            arw_pkg::S_PROBE:  cmd.op = arw_pkg::CELL_PROBE;
            arw_pkg::S_DECIDE:
            begin
                if (!hit_any)
                begin
                    cmd.op = arw_pkg::CELL_SET;
                end
            end
            default:           cmd.op = arw_pkg::CELL_HOLD;
        endcase
    end

    assign pkt_in.ready = (state_reg == arw_pkg::S_IDLE);

    // sequencer and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= arw_pkg::S_IDLE;
            highest_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == arw_pkg::S_CLASS && !zero_reg && new_reg)
            begin
                highest_reg <= cnt_reg;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            arw_pkg::S_IDLE:
            begin
                if (pkt_in.valid)
                begin
                    cnt_reg <= pkt_in.counter;
                end
            end
            arw_pkg::S_DIFF:
            begin
                zero_reg <= (cnt_reg == '0);
                new_reg  <= (cnt_reg > highest_reg);
                diff_reg <= (cnt_reg > highest_reg) ? (cnt_reg - highest_reg)
                                                    : (highest_reg - cnt_reg);
            end
            arw_pkg::S_CLASS:
            begin
                wcnt_reg <= word_sel;
                if (zero_reg)
                begin
                    res_acc_reg    <= 1'b0;
                    res_status_reg <= arw_pkg::ST_ZERO;
                end
                else if (new_reg)
                begin
                    res_acc_reg    <= 1'b1;
                    res_status_reg <= arw_pkg::ST_NEW_HIGH;
                end
                else if (too_far)
                begin
                    res_acc_reg    <= 1'b0;
                    res_status_reg <= arw_pkg::ST_TOO_OLD;
                end
            end
            arw_pkg::S_WSHIFT: wcnt_reg <= wcnt_reg - IDX_W'(1);
            arw_pkg::S_DECIDE:
            begin
                res_acc_reg    <= !hit_any;
                res_status_reg <= hit_any ? arw_pkg::ST_REPLAY : arw_pkg::ST_IN_WINDOW;
            end
            default:
            begin
            end
        endcase
    end

    // result register parts the sequencer from the output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == arw_pkg::S_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == arw_pkg::S_DONE && out_free)
        begin
            out_acc_reg    <= res_acc_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign res_out.valid    = out_valid_reg;
    assign res_out.accepted = out_acc_reg;
    assign res_out.status   = out_status_reg;

    // chain of bitmap cells, word 0 holds the newest counters
    for (genvar w = 0; w < WINDOW_WORDS; w++)
    begin : g_cell
        logic [arw_pkg::WORD_W-1:0] prev;

        if (w == 0)
        begin : g_first
            assign prev = '0;
        end
        else
        begin : g_rest
            assign prev = words[w-1];
        end

        arw_cell #(
            .INDEX (w),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .word_sel  (word_sel),
            .prev_word (prev),
            .word      (words[w]),
            .hit       (hits[w])
        );
    end

    // checks
    `ARW_ASSERT(a_out_rise_from_done, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == arw_pkg::S_DONE), "result shown without a finished transaction")
    `ARW_ASSERT(a_accept_matches_status, clk, rst_n, out_valid_reg |-> (out_acc_reg == (out_status_reg == arw_pkg::ST_NEW_HIGH || out_status_reg == arw_pkg::ST_IN_WINDOW)), "accept flag disagrees with status")
    `ARW_ASSERT(a_highest_monotonic, clk, rst_n, 1'b1 |=> (highest_reg >= $past(highest_reg)), "highest counter went down")
    `ARW_ASSERT(a_wshift_count_live, clk, rst_n, (state_reg == arw_pkg::S_WSHIFT) |-> (wcnt_reg != '0), "word shift with no words left")
    `ARW_ASSERT_ALWAYS(a_ready_only_idle, clk, pkt_in.ready |-> !(state_reg == arw_pkg::S_DONE), "input taken while a result is pending")

endmodule

`default_nettype wire
